// ----- design/kmsm_pkg.sv -----
// Package for the keyed multi-stack manager.
// Holds field widths, default sizes, opcode and status codes, the sequencer
// states and the command record that travels from the front end to the back end.
package kmsm_pkg;

  localparam int NUM_STACKS_DEF = 10;
  localparam int MAX_DEPTH_DEF  = 256;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int KEY_W  = 32;
  localparam int CAP_W  = 9;
  localparam int HDL_W  = 4;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 3;
  localparam int OP_W   = 2;
  localparam int HEXT_W = 8;

  localparam int KEY_LO = 0;
  localparam int CAP_LO = KEY_LO + KEY_W;
  localparam int HDL_LO = CAP_LO + CAP_W;
  localparam int VAL_LO = HDL_LO + HDL_W;
  localparam int IN_TDATA_W = ((VAL_LO + VAL_W + 7) / 8) * 8;

  localparam int STAT_LO  = 0;
  localparam int HOUT_LO  = STAT_LO + STAT_W;
  localparam int PVAL_LO  = HOUT_LO + HDL_W;
  localparam int FOUND_LO = PVAL_LO + VAL_W;
  localparam int OUT_TDATA_W = ((FOUND_LO + 1 + 7) / 8) * 8;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [KEY_W-1:0] KEY_FREED = 32'h7FFF_FFFF;

  typedef enum logic [OP_W-1:0] {
    OP_GET,
    OP_PUSH,
    OP_POP,
    OP_REMOVE
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK,
    STAT_NOSPACE,
    STAT_FULL,
    STAT_EMPTY,
    STAT_STALE
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_EXEC
  } state_t;

  typedef struct packed {
    op_t               op;
    logic [KEY_W-1:0]  key;
    logic [CAP_W-1:0]  cap;
    logic [HEXT_W-1:0] hdl;
    logic              h_ok;
    logic [VAL_W-1:0]  value;
  } cmd_t;

endpackage

// ----- design/kmsm_front.sv -----
// Front end of the keyed multi-stack manager.
// Unpacks an input beat, clamps the capacity and range-checks the handle,
// and hands the resulting command to the queue. Depends on kmsm_pkg.
module kmsm_front import kmsm_pkg::*; #(
  parameter int NUM_STACKS = NUM_STACKS_DEF,
  parameter int MAX_DEPTH  = MAX_DEPTH_DEF
) (
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic [OP_W-1:0]       in_tuser,
  output logic                  q_wr_valid,
  input  logic                  q_wr_ready,
  output cmd_t                  q_wr_data
);

  localparam logic [31:0] MAX_DEPTH_U = 32'(MAX_DEPTH);
  localparam logic [HEXT_W-1:0] NUM_STACKS_U = HEXT_W'(NUM_STACKS);

  logic [CAP_W-1:0]  cap_raw;
  logic [CAP_W-1:0]  cap_clamped;
  logic [HEXT_W-1:0] hdl_ext;

  assign cap_raw = in_tdata[CAP_LO +: CAP_W];
  assign hdl_ext = HEXT_W'(in_tdata[HDL_LO +: HDL_W]);

  always_comb begin
    if (cap_raw == '0) begin
      cap_clamped = CAP_W'(1);
    end else if (32'(cap_raw) > MAX_DEPTH_U) begin
      cap_clamped = CAP_W'(MAX_DEPTH_U);
    end else begin
      cap_clamped = cap_raw;
    end
  end

  always_comb begin
    q_wr_data.op    = op_t'(in_tuser);
    q_wr_data.key   = in_tdata[KEY_LO +: KEY_W];
    q_wr_data.cap   = cap_clamped;
    q_wr_data.hdl   = hdl_ext;
    q_wr_data.h_ok  = (hdl_ext < NUM_STACKS_U);
    q_wr_data.value = in_tdata[VAL_LO +: VAL_W];
  end

  assign q_wr_valid = in_tvalid;
  assign in_tready  = q_wr_ready;

endmodule

// ----- design/kmsm_fifo.sv -----
// Command queue of the keyed multi-stack manager.
// A short first-in first-out buffer of decoded commands between the front end
// and the back end. Depends on kmsm_pkg.
module kmsm_fifo import kmsm_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  cmd_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output cmd_t rd_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  cmd_t          buf_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r;
  logic [PW-1:0] rd_ptr_nxt;
  logic [NW-1:0] count_r;
  logic [NW-1:0] count_nxt;
  logic          do_wr;
  logic          do_rd;

  assign wr_ready = (count_r != NW'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = buf_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + NW'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      buf_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ----- design/kmsm_back.sv -----
// Back end of the keyed multi-stack manager.
// Holds the descriptor table, the shared element memory and the result
// register, and runs each command as a lookup step and an execute step.
// Depends on kmsm_pkg.
module kmsm_back import kmsm_pkg::*; #(
  parameter int NUM_STACKS = NUM_STACKS_DEF,
  parameter int MAX_DEPTH  = MAX_DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_rd_valid,
  output logic                   q_rd_ready,
  input  cmd_t                   q_rd_data,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int HW        = $clog2(NUM_STACKS);
  localparam int DW        = $clog2(MAX_DEPTH);
  localparam int CW        = $clog2(MAX_DEPTH + 1);
  localparam int MW        = (CW > CAP_W) ? CW : CAP_W;
  localparam int MEM_DEPTH = NUM_STACKS << DW;
  localparam int AW        = HW + DW;

  state_t                  state_r;
  state_t                  state_nxt;
  cmd_t                    cmd_r;
  cmd_t                    cmd_nxt;

  logic [NUM_STACKS-1:0]   in_use_r;
  logic [NUM_STACKS-1:0]   in_use_nxt;
  logic [KEY_W-1:0]        key_r     [NUM_STACKS];
  logic [KEY_W-1:0]        key_nxt   [NUM_STACKS];
  logic [CAP_W-1:0]        cap_r     [NUM_STACKS];
  logic [CAP_W-1:0]        cap_nxt   [NUM_STACKS];
  logic [CW-1:0]           fill_r    [NUM_STACKS];
  logic [CW-1:0]           fill_nxt  [NUM_STACKS];
  logic [NUM_STACKS-1:0]   match_r;
  logic [NUM_STACKS-1:0]   match_nxt;
  logic [NUM_STACKS-1:0]   free_r;
  logic [NUM_STACKS-1:0]   free_nxt;
  logic [NUM_STACKS-1:0]   match_cmp;

  logic [DATA_WIDTH-1:0]   mem [MEM_DEPTH];
  logic [DATA_WIDTH-1:0]   mem_q_r;
  logic                    mem_we;
  logic                    mem_re;
  logic [AW-1:0]           mem_waddr;
  logic [AW-1:0]           mem_raddr;
  logic [DATA_WIDTH-1:0]   mem_wdata;

  logic                    out_valid_r;
  logic                    out_valid_nxt;
  status_t                 status_r;
  status_t                 status_nxt;
  logic [HDL_W-1:0]        hout_r;
  logic [HDL_W-1:0]        hout_nxt;
  logic [VAL_W-1:0]        pval_r;
  logic [VAL_W-1:0]        pval_nxt;
  logic                    found_r;
  logic                    found_nxt;

  logic [HW-1:0]           h_idx;
  logic [CW-1:0]           cur_fill;
  logic [CW-1:0]           fill_dec;
  logic [CAP_W-1:0]        cur_cap;
  logic                    cur_used;
  logic [HW-1:0]           match_idx;
  logic [HW-1:0]           free_idx;
  logic                    can_finish;
  logic                    overfill;

  assign h_idx    = cmd_r.hdl[HW-1:0];
  assign cur_fill = fill_r[h_idx];
  assign cur_cap  = cap_r[h_idx];
  assign cur_used = in_use_r[h_idx];
  assign fill_dec = cur_fill - CW'(1);

  always_comb begin
    for (int i = 0; i < NUM_STACKS; i++) begin
      match_cmp[i] = in_use_r[i] && (key_r[i] == cmd_r.key);
    end
  end

  always_comb begin
    match_idx = '0;
    free_idx  = '0;
    for (int i = NUM_STACKS - 1; i >= 0; i--) begin
      if (match_r[i]) begin
        match_idx = HW'(i);
      end
      if (free_r[i]) begin
        free_idx = HW'(i);
      end
    end
  end

  assign can_finish = !out_valid_r || out_tready;
  assign mem_waddr  = {h_idx, cur_fill[DW-1:0]};
  assign mem_raddr  = {h_idx, fill_dec[DW-1:0]};
  assign mem_wdata  = DATA_WIDTH'(cmd_r.value);

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    in_use_nxt    = in_use_r;
    key_nxt       = key_r;
    cap_nxt       = cap_r;
    fill_nxt      = fill_r;
    match_nxt     = match_r;
    free_nxt      = free_r;
    out_valid_nxt = out_valid_r && !out_tready;
    status_nxt    = status_r;
    hout_nxt      = hout_r;
    pval_nxt      = pval_r;
    found_nxt     = found_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    q_rd_ready    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        q_rd_ready = 1'b1;
        if (q_rd_valid) begin
          cmd_nxt   = q_rd_data;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        match_nxt = match_cmp;
        free_nxt  = ~in_use_r;
        mem_re    = (cmd_r.op == OP_POP) && cmd_r.h_ok;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (can_finish) begin
          out_valid_nxt = 1'b1;
          status_nxt    = STAT_OK;
          hout_nxt      = '0;
          pval_nxt      = '0;
          found_nxt     = 1'b0;
          if (cmd_r.op == OP_GET) begin
            if (match_r != '0) begin
              hout_nxt  = HDL_W'(match_idx);
              found_nxt = 1'b1;
            end else if (free_r != '0) begin
              in_use_nxt[free_idx] = 1'b1;
              key_nxt[free_idx]    = cmd_r.key;
              cap_nxt[free_idx]    = cmd_r.cap;
              fill_nxt[free_idx]   = '0;
              hout_nxt             = HDL_W'(free_idx);
            end else begin
              status_nxt = STAT_NOSPACE;
            end
          end else if (!cmd_r.h_ok) begin
            status_nxt = STAT_STALE;
          end else if (cmd_r.op == OP_REMOVE) begin
            in_use_nxt[h_idx] = 1'b0;
            key_nxt[h_idx]    = KEY_FREED;
            fill_nxt[h_idx]   = '0;
          end else if (!cur_used) begin
            status_nxt = STAT_STALE;
          end else if (cmd_r.op == OP_PUSH) begin
            if (MW'(cur_fill) >= MW'(cur_cap)) begin
              status_nxt = STAT_FULL;
            end else begin
              mem_we          = 1'b1;
              fill_nxt[h_idx] = cur_fill + CW'(1);
            end
          end else begin
            if (cur_fill == '0) begin
              status_nxt = STAT_EMPTY;
            end else begin
              fill_nxt[h_idx] = fill_dec;
              pval_nxt        = VAL_W'(mem_q_r);
            end
          end
          q_rd_ready = 1'b1;
          if (q_rd_valid) begin
            cmd_nxt   = q_rd_data;
            state_nxt = S_LOOK;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      in_use_r    <= '0;
      match_r     <= '0;
      free_r      <= '0;
      for (int i = 0; i < NUM_STACKS; i++) begin
        key_r[i]  <= '0;
        cap_r[i]  <= '0;
        fill_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      in_use_r    <= in_use_nxt;
      match_r     <= match_nxt;
      free_r      <= free_nxt;
      key_r       <= key_nxt;
      cap_r       <= cap_nxt;
      fill_r      <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    status_r <= status_nxt;
    hout_r   <= hout_nxt;
    pval_r   <= pval_nxt;
    found_r  <= found_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      mem_q_r <= mem[mem_raddr];
    end
  end

  assign out_tvalid = out_valid_r;
  always_comb begin
    out_tdata                        = '0;
    out_tdata[STAT_LO +: STAT_W]     = status_r;
    out_tdata[HOUT_LO +: HDL_W]      = hout_r;
    out_tdata[PVAL_LO +: VAL_W]      = pval_r;
    out_tdata[FOUND_LO]              = found_r;
  end

  always_comb begin
    overfill = 1'b0;
    for (int i = 0; i < NUM_STACKS; i++) begin
      if (in_use_r[i] && (MW'(fill_r[i]) > MW'(cap_r[i]))) begin
        overfill = 1'b1;
      end
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n) !overfill)
    else $error("A stack holds more elements than its capacity.");

  a_look_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LOOK |=> state_r == S_EXEC)
    else $error("Lookup step was not followed by the execute step.");

  a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_EXEC)
    else $error("A result appeared without an execute step.");

  a_match_not_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EXEC |-> (match_r & free_r) == '0)
    else $error("A descriptor was seen both as a key match and as free.");

endmodule

// ----- design/keyed_multi_stack_manager.sv -----
// Keyed multi-stack manager: one result beat for every input beat.
// Each accepted beat passes through the queue and then the lookup and execute steps of
// the back end, which takes a new command only as it finishes one and stalls on out_tready.
// Reset: synchronous active-low rst_n frees every descriptor and empties the queue;
// the element memory is not cleared and needs no clearing pass.
module keyed_multi_stack_manager import kmsm_pkg::*; #(
  parameter int NUM_STACKS = NUM_STACKS_DEF,
  parameter int MAX_DEPTH  = MAX_DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // stack_key, capacity, handle, push_value
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // opcode
  input  logic [OP_W-1:0]        in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // status, handle_out, pop_value, found_existing
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic q_wr_valid;
  logic q_wr_ready;
  cmd_t q_wr_data;
  logic q_rd_valid;
  logic q_rd_ready;
  cmd_t q_rd_data;

  kmsm_front #(
    .NUM_STACKS (NUM_STACKS),
    .MAX_DEPTH  (MAX_DEPTH)
  ) u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .q_wr_valid (q_wr_valid),
    .q_wr_ready (q_wr_ready),
    .q_wr_data  (q_wr_data)
  );

  kmsm_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (q_wr_valid),
    .wr_ready (q_wr_ready),
    .wr_data  (q_wr_data),
    .rd_valid (q_rd_valid),
    .rd_ready (q_rd_ready),
    .rd_data  (q_rd_data)
  );

  kmsm_back #(
    .NUM_STACKS (NUM_STACKS),
    .MAX_DEPTH  (MAX_DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_rd_valid (q_rd_valid),
    .q_rd_ready (q_rd_ready),
    .q_rd_data  (q_rd_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
